// ===== hdl/masked_signature_scanner_core_defines.svh =====
// Assertion macros shared by the scanner RTL.
// Define NO_ASSERTIONS to compile the checks away.
`ifndef MASKED_SIGNATURE_SCANNER_CORE_DEFINES_SVH
`define MASKED_SIGNATURE_SCANNER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MSS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MSS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MSS_ASSERT(label, clk, rst, prop, msg)
`define MSS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== hdl/msscan_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msscan_pkg
// Types, constants and the pattern shared by the signature scanner modules.
// ----------------------------------------------------------------------------
package msscan_pkg;

   localparam int unsigned PatternLength = 24;
   localparam int unsigned KnownLength   = 24;
   localparam int unsigned FillWidth     = $clog2(PatternLength + 1);

   localparam logic [31:0] LimitReset = 32'd134217728;

   localparam logic [1:0] StNone      = 2'd0;
   localparam logic [1:0] StUnique    = 2'd1;
   localparam logic [1:0] StAmbiguous = 2'd2;
   localparam logic [1:0] StBudget    = 2'd3;

   localparam logic [7:0] PatValue [KnownLength] = '{
      8'h48, 8'h8d, 8'h0d, 8'h00, 8'h00, 8'h00, 8'h00, 8'he8,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h84, 8'hc0, 8'h48, 8'h8d,
      8'h0d, 8'h00, 8'h00, 8'h00, 8'h00, 8'h49, 8'h8b, 8'hd4
   };
   localparam logic PatCare [KnownLength] = '{
      1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1,
      1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1
   };

   typedef logic [7:0] octet_type;

   typedef struct packed {
      logic shift;
      logic restart;
      logic flush;
   } win_ctl_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] disp;
   } win_stat_type;

   // True when window position k accepts byte b. Positions past the known
   // pattern are wildcards.
   function automatic logic pat_accepts(int unsigned k, octet_type b);
      logic ok;
      ok = 1'b1;
      if (k < KnownLength) begin
         ok = !PatCare[k] || (b == PatValue[k]);
      end
      return ok;
   endfunction

endpackage

// ===== hdl/msscan_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msscan_if
// Valid/ready channels of the signature scanner: byte items, results and
// the budget register write.
// ----------------------------------------------------------------------------
interface msscan_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  scan_byte;
   logic [31:0] byte_rva;
   logic        region_start;
   logic        scan_end;

   modport source(output valid, scan_byte, byte_rva, region_start, scan_end,
                  input ready);
   modport sink(input valid, scan_byte, byte_rva, region_start, scan_end,
                output ready);
endinterface

interface msscan_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  scan_status;
   logic [31:0] signature_rva;
   logic [31:0] target_rva;

   modport source(output valid, scan_status, signature_rva, target_rva,
                  input ready);
   modport sink(input valid, scan_status, signature_rva, target_rva,
                output ready);
endinterface

interface msscan_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] scan_byte_limit;

   modport source(output valid, scan_byte_limit, input ready);
   modport sink(input valid, scan_byte_limit, output ready);
endinterface

// ===== hdl/msscan_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msscan_window
// Sliding byte window with fill count and a full parallel masked compare
// against the pattern, evaluated on the window as it is after this shift.
// ----------------------------------------------------------------------------
`include "masked_signature_scanner_core_defines.svh"

module msscan_window (
   input  logic                     clock,
   input  logic                     reset,
   input  msscan_pkg::win_ctl_type  ctl,
   input  msscan_pkg::octet_type    byte_in,
   output msscan_pkg::win_stat_type stat
);

   localparam int unsigned Len = msscan_pkg::PatternLength;
   localparam int unsigned Fw  = msscan_pkg::FillWidth;

   msscan_pkg::octet_type window_ff [Len];
   msscan_pkg::octet_type window_in [Len];
   msscan_pkg::octet_type shifted [Len];
   logic [Fw-1:0]         fill_ff;
   logic [Fw-1:0]         fill_in;
   logic [Fw-1:0]         fill_shifted;
   logic                  all_ok;
   logic                  restart_go;

   always_comb begin
      for (int unsigned k = 0; k < Len - 1; k++) begin
         shifted[k] = ctl.restart ? 8'd0 : window_ff[k + 1];
      end
      shifted[Len - 1] = byte_in;

      if (ctl.restart) begin
         fill_shifted = Fw'(1);
      end else if (fill_ff < Fw'(Len)) begin
         fill_shifted = fill_ff + Fw'(1);
      end else begin
         fill_shifted = fill_ff;
      end

      all_ok = 1'b1;
      for (int unsigned k = 0; k < Len; k++) begin
         if (!msscan_pkg::pat_accepts(k, shifted[k])) begin
            all_ok = 1'b0;
         end
      end

      stat.hit  = ctl.shift && (fill_shifted == Fw'(Len)) && all_ok;
      stat.disp = {shifted[6], shifted[5], shifted[4], shifted[3]};

      // A scan end empties the window after the last byte has been judged.
      for (int unsigned k = 0; k < Len; k++) begin
         if (ctl.flush) begin
            window_in[k] = 8'd0;
         end else if (ctl.shift) begin
            window_in[k] = shifted[k];
         end else begin
            window_in[k] = window_ff[k];
         end
      end
      if (ctl.flush) begin
         fill_in = '0;
      end else if (ctl.shift) begin
         fill_in = fill_shifted;
      end else begin
         fill_in = fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int unsigned k = 0; k < Len; k++) begin
         window_ff[k] <= window_in[k];
      end
   end

   assign restart_go = ctl.shift && ctl.restart && !ctl.flush;

   `MSS_ASSERT(a_fill_bounded, clock, reset, (fill_ff <= Fw'(Len)), "window fill overran")
   `MSS_ASSERT(a_restart_fill, clock, reset, restart_go |=> fill_ff == Fw'(1), "fill not reset")
   `MSS_ASSERT(a_flush_empty, clock, reset, ctl.flush |=> fill_ff == '0, "flush kept fill")

endmodule

// ===== hdl/masked_signature_scanner_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_signature_scanner_core
// Streams code bytes through a 24-byte masked pattern window and reports
// one match status per scan on the end item.
// ----------------------------------------------------------------------------
// The core takes one byte item per clock cycle while no end item stalls. An
// accepted item lands in an input register; when it moves on, a single pass
// checks the byte budget, shifts the window unless the scan has stopped,
// compares all pattern positions at once and computes the branch target; an
// end item loads the result register at the same edge, where the result waits.
// The result register decouples the two sides: bytes keep flowing while a
// result waits, and only an end item stalls behind a result not yet taken.
// Write the byte limit only while no scan is in progress.
`include "masked_signature_scanner_core_defines.svh"

module masked_signature_scanner_core (
   input logic          clock,
   input logic          reset,
   msscan_req_if.sink   req_chan,
   msscan_rsp_if.source rsp_chan,
   msscan_csr_if.sink   csr_chan
);

   localparam int unsigned Len = msscan_pkg::PatternLength;

   // Input register.
   logic                  in_valid_ff;
   logic                  in_valid_in;
   msscan_pkg::octet_type in_byte_ff;
   logic [31:0]           in_rva_ff;
   logic                  in_start_ff;
   logic                  in_end_ff;

   // Scan state.
   logic [1:0]  status_ff, status_in, status_new;
   logic [31:0] match_ff, match_in, match_new;
   logic [31:0] target_ff, target_in, target_new;
   logic [31:0] bytes_ff, bytes_in, bytes_new;
   logic [31:0] limit_ff;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff;
   logic [31:0] rsp_sig_ff;
   logic [31:0] rsp_tgt_ff;

   logic                     advance;
   logic                     stopped;
   logic                     over_budget;
   logic [31:0]              match_addr;
   logic [33:0]              target_sum;
   logic [31:0]              target_val;
   msscan_pkg::win_ctl_type  win_ctl;
   msscan_pkg::win_stat_type win_stat;

   // Assertion helpers.
   logic stop_go;
   logic end_go;
   logic rsp_other;
   logic rsp_zero;
   logic end_done;
   logic over_limit;

   assign advance  = in_valid_ff && (!in_end_ff || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   assign in_valid_in = req_chan.valid ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   assign stopped     = (status_ff == msscan_pkg::StAmbiguous) ||
                        (status_ff == msscan_pkg::StBudget);
   assign over_budget = (bytes_ff >= limit_ff);

   assign win_ctl.shift   = advance && !stopped && !over_budget;
   assign win_ctl.restart = in_start_ff;
   assign win_ctl.flush   = advance && in_end_ff;

   msscan_window u_window (
      .clock   (clock),
      .reset   (reset),
      .ctl     (win_ctl),
      .byte_in (in_byte_ff),
      .stat    (win_stat)
   );

   // The match starts PatternLength-1 bytes before the byte that completes it.
   // The sum is kept 34 bits wide so a target below zero or past 32 bits shows
   // in the top two bits.
   assign match_addr = in_rva_ff - 32'(Len - 1);
   assign target_sum = {2'b00, match_addr} + 34'd7 +
                       {{2{win_stat.disp[31]}}, win_stat.disp};
   assign target_val = (target_sum[33:32] == 2'b00) ? target_sum[31:0] : 32'd0;

   always_comb begin
      status_new = status_ff;
      match_new  = match_ff;
      target_new = target_ff;
      bytes_new  = bytes_ff;
      if (advance && !stopped) begin
         if (over_budget) begin
            status_new = msscan_pkg::StBudget;
         end else begin
            bytes_new = bytes_ff + 32'd1;
            if (win_stat.hit) begin
               if (status_ff == msscan_pkg::StUnique) begin
                  status_new = msscan_pkg::StAmbiguous;
               end else begin
                  status_new = msscan_pkg::StUnique;
                  match_new  = match_addr;
                  target_new = target_val;
               end
            end
         end
      end

      if (win_ctl.flush) begin
         status_in = msscan_pkg::StNone;
         match_in  = '0;
         target_in = '0;
         bytes_in  = '0;
      end else begin
         status_in = status_new;
         match_in  = match_new;
         target_in = target_new;
         bytes_in  = bytes_new;
      end

      if (win_ctl.flush) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         status_ff    <= msscan_pkg::StNone;
         match_ff     <= '0;
         target_ff    <= '0;
         bytes_ff     <= '0;
         limit_ff     <= msscan_pkg::LimitReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         status_ff    <= status_in;
         match_ff     <= match_in;
         target_ff    <= target_in;
         bytes_ff     <= bytes_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid) begin
            limit_ff <= csr_chan.scan_byte_limit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff  <= req_chan.scan_byte;
         in_rva_ff   <= req_chan.byte_rva;
         in_start_ff <= req_chan.region_start;
         in_end_ff   <= req_chan.scan_end;
      end
      if (win_ctl.flush) begin
         rsp_status_ff <= status_new;
         rsp_sig_ff    <= (status_new == msscan_pkg::StUnique) ? match_new : 32'd0;
         rsp_tgt_ff    <= (status_new == msscan_pkg::StUnique) ? target_new : 32'd0;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.scan_status   = rsp_status_ff;
   assign rsp_chan.signature_rva = rsp_sig_ff;
   assign rsp_chan.target_rva    = rsp_tgt_ff;

   assign stop_go    = advance && stopped && !in_end_ff;
   assign end_go     = advance && in_end_ff;
   assign rsp_other  = rsp_valid_ff && (rsp_status_ff != msscan_pkg::StUnique);
   assign rsp_zero   = (rsp_sig_ff == 32'd0) && (rsp_tgt_ff == 32'd0);
   assign end_done   = (status_ff == msscan_pkg::StNone) && (bytes_ff == 32'd0) &&
                       rsp_valid_ff;
   assign over_limit = (bytes_ff > limit_ff);

   `MSS_ASSERT(a_stop_count, clock, reset, stop_go |=> $stable(bytes_ff), "stopped scan counted")
   `MSS_ASSERT(a_nonunique_zero, clock, reset, rsp_other |-> rsp_zero, "non-unique address")
   `MSS_ASSERT(a_end_clears, clock, reset, end_go |=> end_done, "scan end did not clear")
   `MSS_ASSERT(a_budget, clock, reset, over_limit |-> $past(csr_chan.valid), "count over budget")

endmodule
